// ===== rtl/core/median_filter_2d_core_assert.svh =====
// assertion macros shared by the median filter rtl
// no dependencies; included by the modules that carry checks
`ifndef MEDIAN_FILTER_2D_CORE_ASSERT_SVH
`define MEDIAN_FILTER_2D_CORE_ASSERT_SVH

// property that holds at every edge out of reset
`define MF2D_ASSERT_ALWAYS(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("median filter check failed");

// same-cycle implication
`define MF2D_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("median filter check failed");

// next-cycle implication
`define MF2D_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("median filter check failed");

`endif

// ===== rtl/core/mf2d_pkg.sv =====
// shared types, constants and helper functions of the median filter
// no dependencies
`default_nettype none

package mf2d_pkg;

    localparam int unsigned DEF_MAX_WIDTH = 1024;
    localparam int unsigned DEF_MAX_WIN   = 7;

    localparam int unsigned PIX_W   = 8;
    localparam int unsigned DATA_W  = 24;
    localparam int unsigned ROW_W   = 16;
    localparam int unsigned WIN_W   = 3;
    localparam int unsigned IMGW_W  = 11;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CFG_A_W = 2;
    localparam int unsigned REFL_W  = 18;
    localparam int unsigned WIN_HW_LIMIT = 7;

    localparam logic [IMGW_W-1:0] RST_IMAGE_WIDTH  = IMGW_W'(640);
    localparam logic [ROW_W-1:0]  RST_IMAGE_HEIGHT = ROW_W'(480);
    localparam logic [WIN_W-1:0]  RST_WINDOW       = WIN_W'(3);

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    typedef enum logic [CFG_A_W-1:0] {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_WINDOW_HEIGHT = 2'd2,
        REG_WINDOW_WIDTH  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic             start;
        logic             rd;
        logic             wr;
        logic             load_out;
        logic             frame_last;
        logic [WIN_W-1:0] win_h;
        logic [WIN_W-1:0] win_w;
    } mf2d_cmd_t;

    typedef struct packed {
        logic rd_last;
        logic out_busy;
    } mf2d_status_t;

    function automatic logic [WIN_W-1:0] eff_win(input logic [WIN_W-1:0] v,
                                                 input logic [WIN_W-1:0] cap);
        logic [WIN_W-1:0] r;
        r = v;
        if (r == '0) r = WIN_W'(1);
        if (!r[0]) r = r - WIN_W'(1);
        if (r > cap) r = cap;
        return r;
    endfunction

    // mirror about the edge without repeating it, then clamp
    function automatic logic [REFL_W-1:0] reflect(input logic signed [REFL_W-1:0] idx,
                                                  input logic signed [REFL_W-1:0] n);
        logic signed [REFL_W-1:0] r;
        logic signed [REFL_W-1:0] nm1;
        nm1 = n - REFL_W'(1);
        r = idx;
        if (r < 0) r = -r;
        if (r > nm1) r = (nm1 + nm1) - r;
        if (r < 0) r = '0;
        if (r > nm1) r = nm1;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mf2d_ctrl.sv =====
// controller: configuration registers, image positions and result sequencing
// depends on mf2d_pkg and median_filter_2d_core_assert.svh
`default_nettype none
`include "median_filter_2d_core_assert.svh"

module mf2d_ctrl #(
    parameter int unsigned MAX_WIDTH = 1024,
    parameter int unsigned MAX_WIN   = 7,
    localparam int unsigned COL_W    = $clog2(MAX_WIDTH),
    localparam int unsigned WEF_W    = $clog2(MAX_WIDTH + 1)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic                          s_tuser,
    input  wire logic                          cfg_we,
    input  wire logic [mf2d_pkg::CFG_A_W-1:0]  cfg_addr,
    input  wire logic [mf2d_pkg::CFG_W-1:0]    cfg_wdata,
    input  wire mf2d_pkg::mf2d_status_t        status,
    output mf2d_pkg::mf2d_cmd_t                cmd,
    output logic [mf2d_pkg::ROW_W-1:0]         in_row,
    output logic [COL_W-1:0]                   in_col,
    output logic [mf2d_pkg::ROW_W-1:0]         out_row,
    output logic [COL_W-1:0]                   out_col,
    output logic [WEF_W-1:0]                   w_eff,
    output logic [mf2d_pkg::ROW_W-1:0]         h_eff
);
    import mf2d_pkg::*;

    localparam int unsigned WIN_ODD  = (MAX_WIN % 2 == 1) ? MAX_WIN : MAX_WIN - 1;
    localparam int unsigned WIN_LIM  = (WIN_ODD > WIN_HW_LIMIT) ? WIN_HW_LIMIT : WIN_ODD;
    localparam int unsigned HALF_MAX = WIN_LIM / 2;
    localparam int unsigned LAG_MAX  = HALF_MAX * MAX_WIDTH + HALF_MAX;
    localparam int unsigned PEND_W   = $clog2(LAG_MAX + 2);
    localparam int unsigned CMP_W    = (WEF_W > IMGW_W) ? WEF_W : IMGW_W;
    localparam int unsigned CW1      = COL_W + 1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_GATHER = 4'b0010,
        ST_FINISH = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [IMGW_W-1:0]   img_w_reg;
    logic [ROW_W-1:0]    img_h_reg;
    logic [WIN_W-1:0]    win_h_reg, win_w_reg;
    logic [ROW_W-1:0]    in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [COL_W-1:0]    in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [PEND_W-1:0]   pending_reg, pending_next;
    logic                in_done_reg, in_done_next;
    logic [WIN_W-1:0]    wh, ww;
    logic [PEND_W-1:0]   lag;
    logic                accept;
    logic                col_last_in, row_last_in, col_last_out, row_last_out;
    logic [CMP_W-1:0]    w_cmp;

    always_comb begin
        w_cmp = CMP_W'(img_w_reg);
        if (img_w_reg == '0) begin
            w_eff = WEF_W'(1);
        end else if (w_cmp > CMP_W'(MAX_WIDTH)) begin
            w_eff = WEF_W'(MAX_WIDTH);
        end else begin
            w_eff = WEF_W'(img_w_reg);
        end
    end

    assign h_eff = (img_h_reg == '0) ? ROW_W'(1) : img_h_reg;
    assign wh    = eff_win(win_h_reg, WIN_W'(WIN_LIM));
    assign ww    = eff_win(win_w_reg, WIN_W'(WIN_LIM));
    assign lag   = PEND_W'(wh >> 1) * PEND_W'(w_eff) + PEND_W'(ww >> 1);

    assign col_last_in  = (CW1'(in_col_reg) + CW1'(1)) >= CW1'(w_eff);
    assign row_last_in  = ({1'b0, in_row_reg} + 17'd1) >= {1'b0, h_eff};
    assign col_last_out = (CW1'(out_col_reg) + CW1'(1)) >= CW1'(w_eff);
    assign row_last_out = ({1'b0, out_row_reg} + 17'd1) >= {1'b0, h_eff};

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign in_row  = in_row_reg;
    assign in_col  = in_col_reg;
    assign out_row = out_row_reg;
    assign out_col = out_col_reg;

    always_comb begin
        state_next   = state_reg;
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        pending_next = pending_reg;
        in_done_next = in_done_reg;
        cmd          = '0;
        cmd.win_h    = wh;
        cmd.win_w    = ww;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_done_reg) begin
                        cmd.start  = 1'b1;
                        state_next = ST_GATHER;
                    end else if (s_tuser == MODE_PIXEL) begin
                        cmd.wr       = 1'b1;
                        pending_next = pending_reg + PEND_W'(1);
                        if (col_last_in) begin
                            in_col_next = '0;
                            in_row_next = in_row_reg + ROW_W'(1);
                            if (row_last_in) in_done_next = 1'b1;
                        end else begin
                            in_col_next = in_col_reg + COL_W'(1);
                        end
                        if (pending_reg >= lag) begin
                            cmd.start  = 1'b1;
                            state_next = ST_GATHER;
                        end
                    end
                end
            end
            ST_GATHER: begin
                cmd.rd = 1'b1;
                if (status.rd_last) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (!status.out_busy) begin
                    cmd.load_out = 1'b1;
                    pending_next = pending_reg - PEND_W'(1);
                    state_next   = ST_IDLE;
                    if (col_last_out) begin
                        out_col_next = '0;
                        if (row_last_out) begin
                            cmd.frame_last = 1'b1;
                            out_row_next   = '0;
                            in_row_next    = '0;
                            in_col_next    = '0;
                            pending_next   = '0;
                            in_done_next   = 1'b0;
                        end else begin
                            out_row_next = out_row_reg + ROW_W'(1);
                        end
                    end else begin
                        out_col_next = out_col_reg + COL_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_we) begin
            state_next   = ST_IDLE;
            in_row_next  = '0;
            in_col_next  = '0;
            out_row_next = '0;
            out_col_next = '0;
            pending_next = '0;
            in_done_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            img_w_reg   <= RST_IMAGE_WIDTH;
            img_h_reg   <= RST_IMAGE_HEIGHT;
            win_h_reg   <= RST_WINDOW;
            win_w_reg   <= RST_WINDOW;
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            pending_reg <= '0;
            in_done_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
            pending_reg <= pending_next;
            in_done_reg <= in_done_next;
            if (cfg_we) begin
                unique case (cfg_reg_t'(cfg_addr))
                    REG_IMAGE_WIDTH:   img_w_reg <= cfg_wdata[IMGW_W-1:0];
                    REG_IMAGE_HEIGHT:  img_h_reg <= cfg_wdata[ROW_W-1:0];
                    REG_WINDOW_HEIGHT: win_h_reg <= cfg_wdata[WIN_W-1:0];
                    REG_WINDOW_WIDTH:  win_w_reg <= cfg_wdata[WIN_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    logic [PEND_W:0] pend_ext, lag_ext;
    logic [CW1-1:0]  out_col_ext, w_eff_ext;
    assign pend_ext    = (PEND_W+1)'(pending_reg);
    assign lag_ext     = (PEND_W+1)'(lag) + (PEND_W+1)'(1);
    assign out_col_ext = CW1'(out_col_reg);
    assign w_eff_ext   = CW1'(w_eff);

    `MF2D_ASSERT_ALWAYS(a_pend_bound, aclk, aresetn, pend_ext <= lag_ext)
    `MF2D_ASSERT_IMPLY(a_done_pending, aclk, aresetn, in_done_reg, pending_reg != '0)
    `MF2D_ASSERT_ALWAYS(a_out_col, aclk, aresetn, out_col_ext < w_eff_ext)

endmodule

`default_nettype wire

// ===== rtl/core/mf2d_dp.sv =====
// datapath: line store, window address generation, insertion sorters, output register
// depends on mf2d_pkg
`default_nettype none

module mf2d_dp #(
    parameter int unsigned MAX_WIDTH = 1024,
    parameter int unsigned MAX_WIN   = 7,
    localparam int unsigned COL_W    = $clog2(MAX_WIDTH),
    localparam int unsigned WEF_W    = $clog2(MAX_WIDTH + 1)
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire mf2d_pkg::mf2d_cmd_t          cmd,
    output mf2d_pkg::mf2d_status_t            status,
    input  wire logic [mf2d_pkg::ROW_W-1:0]   in_row,
    input  wire logic [COL_W-1:0]             in_col,
    input  wire logic [mf2d_pkg::ROW_W-1:0]   out_row,
    input  wire logic [COL_W-1:0]             out_col,
    input  wire logic [WEF_W-1:0]             w_eff,
    input  wire logic [mf2d_pkg::ROW_W-1:0]   h_eff,
    input  wire logic [mf2d_pkg::DATA_W-1:0]  s_tdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [mf2d_pkg::DATA_W-1:0]       m_tdata,
    output logic                              m_tlast
);
    import mf2d_pkg::*;

    localparam int unsigned WIN_ODD   = (MAX_WIN % 2 == 1) ? MAX_WIN : MAX_WIN - 1;
    localparam int unsigned WIN_LIM   = (WIN_ODD > WIN_HW_LIMIT) ? WIN_HW_LIMIT : WIN_ODD;
    localparam int unsigned SORT_N    = WIN_LIM * WIN_LIM;
    localparam int unsigned CNT_W     = $clog2(SORT_N + 1);
    localparam int unsigned IDX_W     = $clog2(SORT_N);
    localparam int unsigned SLOT_W    = $clog2(WIN_LIM + 1);
    localparam int unsigned ADDR_W    = SLOT_W + COL_W;
    localparam int unsigned MEM_DEPTH = 2 ** ADDR_W;
    localparam int unsigned N_CH      = DATA_W / PIX_W;

    logic [DATA_W-1:0]          mem [MEM_DEPTH];
    logic [DATA_W-1:0]          rd_data_reg;
    logic                       rd_valid_reg;
    logic [WIN_W-1:0]           it_reg, jt_reg;
    logic [CNT_W-1:0]           sort_cnt_reg;
    logic [PIX_W-1:0]           sort_reg  [N_CH][SORT_N];
    logic [PIX_W-1:0]           sort_next [N_CH][SORT_N];
    logic                       gt        [N_CH][SORT_N];
    logic [DATA_W-1:0]          m_tdata_reg;
    logic                       m_tlast_reg, m_tvalid_reg;
    logic signed [REFL_W-1:0]   row_idx, col_idx;
    logic [REFL_W-1:0]          row_r, col_r;
    logic [ADDR_W-1:0]          rd_addr, wr_addr;
    logic [IDX_W-1:0]           k_idx;

    assign status.rd_last  = (it_reg == cmd.win_h - WIN_W'(1)) &&
                             (jt_reg == cmd.win_w - WIN_W'(1));
    assign status.out_busy = m_tvalid_reg && !m_tready;

    assign row_idx = $signed(REFL_W'(out_row) + REFL_W'(it_reg) - REFL_W'(cmd.win_h >> 1));
    assign col_idx = $signed(REFL_W'(out_col) + REFL_W'(jt_reg) - REFL_W'(cmd.win_w >> 1));
    assign row_r   = reflect(row_idx, $signed(REFL_W'(h_eff)));
    assign col_r   = reflect(col_idx, $signed(REFL_W'(w_eff)));
    assign rd_addr = {row_r[SLOT_W-1:0], col_r[COL_W-1:0]};
    assign wr_addr = {in_row[SLOT_W-1:0], in_col};

    always_ff @(posedge aclk) begin
        if (cmd.wr) mem[wr_addr] <= s_tdata;
        if (cmd.rd) rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            it_reg       <= '0;
            jt_reg       <= '0;
            rd_valid_reg <= 1'b0;
            sort_cnt_reg <= '0;
        end else begin
            rd_valid_reg <= cmd.rd;
            if (cmd.start) begin
                it_reg <= '0;
                jt_reg <= '0;
            end else if (cmd.rd) begin
                if (jt_reg == cmd.win_w - WIN_W'(1)) begin
                    jt_reg <= '0;
                    it_reg <= it_reg + WIN_W'(1);
                end else begin
                    jt_reg <= jt_reg + WIN_W'(1);
                end
            end
            if (cmd.start) begin
                sort_cnt_reg <= '0;
            end else if (rd_valid_reg) begin
                sort_cnt_reg <= sort_cnt_reg + CNT_W'(1);
            end
        end
    end

    // insertion into a sorted row, one value per cycle
    always_comb begin
        for (int c = 0; c < N_CH; c++) begin
            for (int p = 0; p < SORT_N; p++) begin
                gt[c][p] = (CNT_W'(p) >= sort_cnt_reg) ||
                           (sort_reg[c][p] > rd_data_reg[c*PIX_W +: PIX_W]);
            end
            sort_next[c][0] = gt[c][0] ? rd_data_reg[c*PIX_W +: PIX_W] : sort_reg[c][0];
            for (int p = 1; p < SORT_N; p++) begin
                if (!gt[c][p]) begin
                    sort_next[c][p] = sort_reg[c][p];
                end else if (gt[c][p-1]) begin
                    sort_next[c][p] = sort_reg[c][p-1];
                end else begin
                    sort_next[c][p] = rd_data_reg[c*PIX_W +: PIX_W];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_valid_reg) sort_reg <= sort_next;
    end

    assign k_idx = IDX_W'(sort_cnt_reg >> 1);

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tdata_reg <= {sort_reg[2][k_idx], sort_reg[1][k_idx], sort_reg[0][k_idx]};
            m_tlast_reg <= cmd.frame_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

// ===== rtl/core/median_filter_2d_core.sv =====
// 2-d median filter on a bgr pixel stream, top level
// depends on mf2d_pkg, mf2d_ctrl and mf2d_dp
//
// usage:
//   s_ channel carries one request per pixel in raster order, s_tuser = 0 for a
//   pixel and 1 for a drain request that flushes pending results once the whole
//   image is in. m_ channel returns the per-channel medians, m_tlast on the
//   bottom-right pixel of the image.
//   results trail the input by (window_height/2)*image_width + window_width/2
//   pixels; after the last pixel one drain request per remaining result.
//   a request that causes no result leaves s_tready high. a request that causes
//   a result holds s_tready low while the window is gathered through the single
//   read port of the line store: one window entry is read and sorted per cycle.
//   a finished result sits in the output register; the next request is taken
//   while it waits, and a new result waits only if the register is still held.
//   reset clears positions and loads 640 x 480 with a 3 x 3 window; the line
//   store is not cleared. any configuration write restarts the image.
`default_nettype none

module median_filter_2d_core #(
    parameter int unsigned MAX_WIDTH = mf2d_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_WIN   = mf2d_pkg::DEF_MAX_WIN
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [mf2d_pkg::DATA_W-1:0]   s_tdata,  // blue_in, green_in, red_in
    input  wire logic                          s_tuser,  // mode
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [mf2d_pkg::DATA_W-1:0]        m_tdata,  // blue_out, green_out, red_out
    output logic                               m_tlast,
    input  wire logic                          cfg_we,
    input  wire logic [mf2d_pkg::CFG_A_W-1:0]  cfg_addr,
    input  wire logic [mf2d_pkg::CFG_W-1:0]    cfg_wdata
);
    import mf2d_pkg::*;

    localparam int unsigned COL_W = $clog2(MAX_WIDTH);
    localparam int unsigned WEF_W = $clog2(MAX_WIDTH + 1);

    mf2d_cmd_t          cmd;
    mf2d_status_t       status;
    logic [ROW_W-1:0]   in_row, out_row, h_eff;
    logic [COL_W-1:0]   in_col, out_col;
    logic [WEF_W-1:0]   w_eff;

    mf2d_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_WIN   (MAX_WIN)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .status    (status),
        .cmd       (cmd),
        .in_row    (in_row),
        .in_col    (in_col),
        .out_row   (out_row),
        .out_col   (out_col),
        .w_eff     (w_eff),
        .h_eff     (h_eff)
    );

    mf2d_dp #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_WIN   (MAX_WIN)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .in_row   (in_row),
        .in_col   (in_col),
        .out_row  (out_row),
        .out_col  (out_col),
        .w_eff    (w_eff),
        .h_eff    (h_eff),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
